@@ design/lpqm_pkg.sv @@
// Shared types and codes for the linked process queue manager.
// Used by lpqm_ctrl, lpqm_dp and linked_process_queue_manager; depends on nothing.
package lpqm_pkg;

  localparam int MODE_W  = 2;
  localparam int QUEUE_W = 3;
  localparam int ENTRY_W = 5;

  // request modes
  localparam logic [MODE_W-1:0] MODE_INSERT       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE_HEAD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE_NAMED = 2'd2;

  // datapath step codes issued by the controller
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_NONE      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CLEAR     = 4'd1;
  localparam logic [STEP_W-1:0] STEP_LOAD      = 4'd2;
  localparam logic [STEP_W-1:0] STEP_INS_FIRST = 4'd3;
  localparam logic [STEP_W-1:0] STEP_INS_READ  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_INS_LINK  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_INS_FIX   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_RH_READ   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_RH_LOCATE = 4'd8;
  localparam logic [STEP_W-1:0] STEP_RN_READ   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_UNLINK    = 4'd10;
  localparam logic [STEP_W-1:0] STEP_FIN_TAIL  = 4'd11;
  localparam logic [STEP_W-1:0] STEP_FIN_NEXT  = 4'd12;
  localparam logic [STEP_W-1:0] STEP_REPORT    = 4'd13;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [QUEUE_W-1:0] queue_select;
    logic [ENTRY_W-1:0] entry_select;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [ENTRY_W-1:0] result_entry;
    logic [ENTRY_W-1:0] head_entry;
    logic               queue_empty;
  } rsp_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic q_ne;
    logic ins_ok;
    logic rh_ok;
    logic rn_ok;
  } sts_t;

endpackage

@@ design/lpqm_dp.sv @@
// Datapath of the linked queue manager: link, tail and owner memories,
// per-queue nonempty flags and the request registers. Depends on lpqm_pkg.
module lpqm_dp import lpqm_pkg::*; #(
  parameter int ENTRIES = 32,
  parameter int QUEUES  = 8
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output logic done,
  output rsp_t rsp
);

  localparam int EW = $clog2(ENTRIES);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  // memories
  logic [EW-1:0] tail_mem [QUEUES];
  logic [EW-1:0] next_mem [ENTRIES];
  logic [EW-1:0] prev_mem [ENTRIES];
  logic [QW:0]   own_mem  [ENTRIES];   // {queued, owner}

  logic [EW-1:0] tail_rd, next_rd, prev_rd;
  logic [QW:0]   own_rd;

  // request and working registers
  logic [MODE_W-1:0]  mode_r;
  logic [QUEUE_W-1:0] q_r;
  logic [ENTRY_W-1:0] e_r;
  logic [EW-1:0]      t, tgt, hd, cnt;
  logic               ok;
  logic [QUEUES-1:0]  nonempty;

  logic [QW-1:0] q_idx;
  logic [EW-1:0] e_idx;
  logic          qv, ev, q_ne, own_queued;

  logic [QW-1:0] tail_ra, tail_wa;
  logic [EW-1:0] own_ra, own_wa, next_ra, next_wa, prev_ra, prev_wa;
  logic [EW-1:0] tail_wd, next_wd, prev_wd;
  logic [QW:0]   own_wd;
  logic          tail_we, next_we, prev_we, own_we, ne_set, ne_clr;

  assign q_idx      = QW'(q_r);
  assign e_idx      = EW'(e_r);
  assign qv         = 32'(q_r) < 32'(QUEUES);
  assign ev         = 32'(e_r) < 32'(ENTRIES);
  assign q_ne       = qv && nonempty[q_idx];
  assign own_queued = own_rd[QW];

  assign sts.clr_last = cnt == EW'(ENTRIES - 1);
  assign sts.q_ne     = q_ne;
  assign sts.ins_ok   = (mode_r == MODE_INSERT) && qv && ev && !own_queued;
  assign sts.rh_ok    = (mode_r == MODE_REMOVE_HEAD) && q_ne;
  assign sts.rn_ok    = (mode_r == MODE_REMOVE_NAMED) && qv && ev && own_queued &&
                        (own_rd[QW-1:0] == q_idx);

  // read addresses
  always_comb begin
    tail_ra = (cmd.step == STEP_LOAD) ? QW'(req.queue_select) : q_idx;
    own_ra  = (cmd.step == STEP_LOAD) ? EW'(req.entry_select) : e_idx;
    case (cmd.step)
      STEP_INS_READ, STEP_RH_READ, STEP_FIN_NEXT: next_ra = tail_rd;
      STEP_RH_LOCATE: next_ra = next_rd;
      default:        next_ra = e_idx;
    endcase
    prev_ra = (cmd.step == STEP_RH_LOCATE) ? next_rd : e_idx;
  end

  // write ports
  always_comb begin
    tail_we = 1'b0;  tail_wa = q_idx;  tail_wd = e_idx;
    next_we = 1'b0;  next_wa = e_idx;  next_wd = e_idx;
    prev_we = 1'b0;  prev_wa = e_idx;  prev_wd = e_idx;
    own_we  = 1'b0;  own_wa  = e_idx;  own_wd  = {1'b1, q_idx};
    ne_set  = 1'b0;
    ne_clr  = 1'b0;
    case (cmd.step)
      STEP_CLEAR: begin
        own_we = 1'b1;
        own_wa = cnt;
        own_wd = '0;
      end
      STEP_INS_FIRST: begin
        // single entry links to itself
        next_we = 1'b1;
        prev_we = 1'b1;
        tail_we = 1'b1;
        own_we  = 1'b1;
        ne_set  = 1'b1;
      end
      STEP_INS_LINK: begin
        next_we = 1'b1;
        next_wd = next_rd;
        prev_we = 1'b1;
        prev_wd = t;
        tail_we = 1'b1;
        own_we  = 1'b1;
      end
      STEP_INS_FIX: begin
        next_we = 1'b1;
        next_wa = t;
        prev_we = 1'b1;
        prev_wa = hd;
      end
      STEP_UNLINK: begin
        own_we = 1'b1;
        own_wa = tgt;
        own_wd = {1'b0, q_idx};
        if (next_rd == tgt) begin
          ne_clr = 1'b1;
        end else begin
          prev_we = 1'b1;
          prev_wa = next_rd;
          prev_wd = prev_rd;
          next_we = 1'b1;
          next_wa = prev_rd;
          next_wd = next_rd;
          // removing the tail moves it back
          if (t == tgt) begin
            tail_we = 1'b1;
            tail_wd = prev_rd;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tail_we) begin
      tail_mem[tail_wa] <= tail_wd;
    end
    tail_rd <= tail_mem[tail_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    next_rd <= next_mem[next_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    prev_rd <= prev_mem[prev_ra];
  end

  always_ff @(posedge clk) begin
    if (own_we) begin
      own_mem[own_wa] <= own_wd;
    end
    own_rd <= own_mem[own_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty <= '0;
      cnt      <= '0;
    end else begin
      if (ne_set) begin
        nonempty[q_idx] <= 1'b1;
      end else if (ne_clr) begin
        nonempty[q_idx] <= 1'b0;
      end
      if (cmd.step == STEP_CLEAR) begin
        cnt <= cnt + EW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.step)
      STEP_LOAD: begin
        mode_r <= req.mode;
        q_r    <= req.queue_select;
        e_r    <= req.entry_select;
        ok     <= 1'b0;
      end
      STEP_INS_FIRST: begin
        ok  <= 1'b1;
        tgt <= e_idx;
      end
      STEP_INS_READ: begin
        ok  <= 1'b1;
        tgt <= e_idx;
        t   <= tail_rd;
      end
      STEP_INS_LINK: begin
        hd <= next_rd;
      end
      STEP_RH_READ: begin
        ok <= 1'b1;
        t  <= tail_rd;
      end
      STEP_RH_LOCATE: begin
        tgt <= next_rd;
      end
      STEP_RN_READ: begin
        ok  <= 1'b1;
        t   <= tail_rd;
        tgt <= e_idx;
      end
      default: begin
      end
    endcase
  end

  assign done             = cmd.step == STEP_REPORT;
  assign rsp.ok           = ok;
  assign rsp.result_entry = ok ? ENTRY_W'(tgt) : '0;
  assign rsp.queue_empty  = !q_ne;
  assign rsp.head_entry   = q_ne ? ENTRY_W'(next_rd) : '0;

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    done && rsp.ok && (mode_r == MODE_INSERT) |-> !rsp.queue_empty)
    else $error("successful insert left queue empty");
  assert property (@(posedge clk) disable iff (rst)
    done && !qv |-> !rsp.ok && rsp.queue_empty)
    else $error("out of range queue reported activity");
  assert property (@(posedge clk) disable iff (rst)
    cmd.step == STEP_INS_LINK |-> $past(cmd.step) == STEP_INS_READ)
    else $error("insert link step without preceding tail read");
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.step) == STEP_FIN_NEXT)
    else $error("result reported before head lookup");
`endif

endmodule

@@ design/lpqm_ctrl.sv @@
// Controller state machine of the linked queue manager: sequences memory
// reads and writes per request and the clearing pass. Depends on lpqm_pkg.
module lpqm_ctrl import lpqm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output logic busy,
  output cmd_t cmd
);

  localparam logic [3:0] ST_CLEAR     = 4'd0;
  localparam logic [3:0] ST_IDLE      = 4'd1;
  localparam logic [3:0] ST_CHECK     = 4'd2;
  localparam logic [3:0] ST_INS_LINK  = 4'd3;
  localparam logic [3:0] ST_INS_FIX   = 4'd4;
  localparam logic [3:0] ST_RH_LOCATE = 4'd5;
  localparam logic [3:0] ST_UNLINK    = 4'd6;
  localparam logic [3:0] ST_FIN_TAIL  = 4'd7;
  localparam logic [3:0] ST_FIN_NEXT  = 4'd8;
  localparam logic [3:0] ST_REPORT    = 4'd9;

  logic [3:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd.step   = STEP_NONE;
    case (state)
      ST_CLEAR: begin
        cmd.step = STEP_CLEAR;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.step   = STEP_LOAD;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.ins_ok && !sts.q_ne) begin
          cmd.step   = STEP_INS_FIRST;
          state_next = ST_FIN_TAIL;
        end else if (sts.ins_ok) begin
          cmd.step   = STEP_INS_READ;
          state_next = ST_INS_LINK;
        end else if (sts.rh_ok) begin
          cmd.step   = STEP_RH_READ;
          state_next = ST_RH_LOCATE;
        end else if (sts.rn_ok) begin
          cmd.step   = STEP_RN_READ;
          state_next = ST_UNLINK;
        end else begin
          // refused: report only
          state_next = ST_FIN_TAIL;
        end
      end
      ST_INS_LINK: begin
        cmd.step   = STEP_INS_LINK;
        state_next = ST_INS_FIX;
      end
      ST_INS_FIX: begin
        cmd.step   = STEP_INS_FIX;
        state_next = ST_FIN_TAIL;
      end
      ST_RH_LOCATE: begin
        cmd.step   = STEP_RH_LOCATE;
        state_next = ST_UNLINK;
      end
      ST_UNLINK: begin
        cmd.step   = STEP_UNLINK;
        state_next = ST_FIN_TAIL;
      end
      ST_FIN_TAIL: begin
        cmd.step   = STEP_FIN_TAIL;
        state_next = ST_FIN_NEXT;
      end
      ST_FIN_NEXT: begin
        cmd.step   = STEP_FIN_NEXT;
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        cmd.step   = STEP_REPORT;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != ST_IDLE;

endmodule

@@ design/linked_process_queue_manager.sv @@
// Top level of the linked queue manager: controller plus datapath.
// Depends on lpqm_pkg, lpqm_ctrl and lpqm_dp.
//
// QUEUES FIFO queues share a pool of ENTRIES entries held as circular doubly
// linked lists in one-read one-write link, tail and owner memories. A transaction is
// taken when start is high and busy is low; its result appears on rsp for one
// cycle with done high and must be captured then, since it cannot be held.
// After reset the block clears the owner memory, entry by entry, with busy high.
// A request passes from start to a check state, then its own steps (none for an
// insert into an empty queue or a refused request, unlink for a named removal,
// link and fix for an insert into a non-empty queue, locate and unlink for a
// head removal), then a tail lookup, a head lookup and the report with done.
// Link reads are registered: each neighbor link is read in one step and rewritten
// in the next; the new head comes from the tail memory, then the next-link memory.
module linked_process_queue_manager import lpqm_pkg::*; #(
  parameter int ENTRIES = 32,
  parameter int QUEUES  = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  cmd_t cmd;
  sts_t sts;

  lpqm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  lpqm_dp #(
    .ENTRIES (ENTRIES),
    .QUEUES  (QUEUES)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .sts  (sts),
    .done (done),
    .rsp  (rsp)
  );

endmodule
